FILE: rtl/pop_pkg.sv
`default_nettype none
package pop_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned LeadW  = 31;
  localparam int unsigned MagW   = CoordW + 1;
  localparam int unsigned ProdW  = LeadW + MagW + 1;
  localparam int unsigned LoW    = 32;
  localparam int unsigned HiW    = ProdW - LoW;
  localparam int unsigned NumW   = 2 * ProdW;
  localparam int unsigned DenW   = 2 * MagW + 1;
  localparam int unsigned QuoW   = 2 * LeadW + 2;
  localparam int unsigned RootW  = QuoW / 2;
  localparam int unsigned Lat    = QuoW + RootW;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam logic RegDirLeft = 1'b0;
  localparam logic RegLead    = 1'b1;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    logic   req_type;
    coord_t start_x;
    coord_t start_y;
    coord_t toward_x;
    coord_t toward_y;
  } in_item_t;

  typedef struct packed {
    coord_t offset_x;
    coord_t offset_y;
    logic   degenerate;
  } out_item_t;

endpackage
`default_nettype wire

FILE: rtl/pop_root_ratio.sv
`default_nettype none
// root_o = isqrt(floor(num_i / den_i)), one restoring step per stage
module pop_root_ratio (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [pop_pkg::NumW-1:0]   num_i,
  input  wire logic [pop_pkg::DenW-1:0]   den_i,
  output logic      [pop_pkg::RootW-1:0]  root_o
);

  localparam int unsigned NumW  = pop_pkg::NumW;
  localparam int unsigned DenW  = pop_pkg::DenW;
  localparam int unsigned QuoW  = pop_pkg::QuoW;
  localparam int unsigned RootW = pop_pkg::RootW;

  logic [DenW-1:0]  drem_q  [QuoW];
  logic [QuoW-1:0]  dword_q [QuoW];
  logic [DenW-1:0]  dden_q  [QuoW];

  logic [RootW+1:0] srem_q  [RootW];
  logic [RootW-1:0] sroot_q [RootW];
  logic [QuoW-1:0]  sword_q [RootW];

  // divider: the word holds the numerator bits still to come on top and
  // the quotient bits gathered so far below
  for (genvar k = 0; k < QuoW; k++) begin : g_div
    logic [DenW-1:0] rem_in;
    logic [QuoW-1:0] word_in;
    logic [DenW-1:0] den_in;
    logic [DenW:0]   trial;
    logic            ge;
    logic [DenW:0]   diff;

    if (k == 0) begin : g_first
      assign rem_in  = DenW'(num_i[NumW-1:QuoW]);
      assign word_in = num_i[QuoW-1:0];
      assign den_in  = den_i;
    end else begin : g_next
      assign rem_in  = drem_q[k-1];
      assign word_in = dword_q[k-1];
      assign den_in  = dden_q[k-1];
    end

    always_comb begin
      trial = {rem_in, word_in[QuoW-1]};
      ge    = (trial >= {1'b0, den_in});
      diff  = trial - {1'b0, den_in};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        drem_q[k]  <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
        dword_q[k] <= {word_in[QuoW-2:0], ge};
        dden_q[k]  <= den_in;
      end
    end
  end

  // square root, two radicand bits per stage
  for (genvar j = 0; j < RootW; j++) begin : g_sqrt
    logic [RootW+1:0] rem_in;
    logic [RootW-1:0] root_in;
    logic [QuoW-1:0]  word_in;
    logic [RootW+3:0] trial;
    logic [RootW+3:0] test;
    logic             ge;
    logic [RootW+3:0] diff;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign word_in = dword_q[QuoW-1];
    end else begin : g_next
      assign rem_in  = srem_q[j-1];
      assign root_in = sroot_q[j-1];
      assign word_in = sword_q[j-1];
    end

    always_comb begin
      trial = {rem_in, word_in[QuoW-1:QuoW-2]};
      test  = (RootW+4)'({root_in, 2'b01});
      ge    = (trial >= test);
      diff  = trial - test;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        srem_q[j]  <= ge ? diff[RootW+1:0] : trial[RootW+1:0];
        sroot_q[j] <= {root_in[RootW-2:0], ge};
        sword_q[j] <= {word_in[QuoW-3:0], 2'b00};
      end
    end
  end

  assign root_o = sroot_q[RootW-1];

endmodule
`default_nettype wire

FILE: rtl/perpendicular_offset_point.sv
// Perpendicular offset point of a segment.
//
// Input channel (in_valid_i / in_stall_o / in_item_i): one segment per item,
// start point and a second point, signed Q16.16, plus the lead-in/lead-out
// selector. Output channel (out_valid_o / out_stall_i / out_item_o): the
// point at the lead distance from the start along the segment normal,
// saturated, with a flag for a zero-length segment (start point returned).
// Configuration goes over the APB port: direction_left at 0x0 (reset 1),
// the lead distance at 0x4 (reset 0); write only while no item is in flight.
//
// The pipeline is five front stages of subtracts and 33-bit multiplies,
// then the 64-stage restoring divider and the 32-stage square root. One item
// is taken every cycle while the skid register is empty. Reset empties the
// pipeline and loads the register defaults.
// When the receiver stalls, the output register holds its item and one more
// lands in a skid register; the whole pipeline then freezes and in_stall_o
// rises until the skid register drains, so nothing is lost or repeated.
`default_nettype none
module perpendicular_offset_point (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire pop_pkg::in_item_t           in_item_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output pop_pkg::out_item_t               out_item_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pop_pkg::AddrW-1:0]   paddr,
  input  wire logic [pop_pkg::DataW-1:0]   pwdata,
  output logic      [pop_pkg::DataW-1:0]   prdata,
  output logic                             pready
);

  localparam int unsigned CoordW = pop_pkg::CoordW;
  localparam int unsigned LeadW  = pop_pkg::LeadW;
  localparam int unsigned MagW   = pop_pkg::MagW;
  localparam int unsigned ProdW  = pop_pkg::ProdW;
  localparam int unsigned LoW    = pop_pkg::LoW;
  localparam int unsigned HiW    = pop_pkg::HiW;
  localparam int unsigned NumW   = pop_pkg::NumW;
  localparam int unsigned DenW   = pop_pkg::DenW;
  localparam int unsigned RootW  = pop_pkg::RootW;
  localparam int unsigned Lat    = pop_pkg::Lat;
  localparam int unsigned DataW  = pop_pkg::DataW;

  typedef struct packed {
    pop_pkg::coord_t sx;
    pop_pkg::coord_t sy;
    logic            negx;
    logic            negy;
    logic            ccw;
    logic            deg;
  } side_t;

  // ---------------------------------------------------------------- config
  logic             dir_q;
  logic [LeadW-1:0] lead_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= 1'b1;
      lead_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        pop_pkg::RegDirLeft: dir_q  <= pwdata[0];
        pop_pkg::RegLead:    lead_q <= pwdata[LeadW-1:0];
        default:             dir_q  <= dir_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      pop_pkg::RegDirLeft: prdata = DataW'(dir_q);
      pop_pkg::RegLead:    prdata = DataW'(lead_q);
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow
  // Advance every stage together; freeze only while the skid register holds.
  logic en;
  logic skid_v_q;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // stage 1: differences, rotation sense
  logic                    v1_q;
  pop_pkg::coord_t         sx1_q, sy1_q;
  logic signed [CoordW:0]  dx1_q, dy1_q;
  logic                    ccw1_q;
  logic [LeadW-1:0]        lead1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx1_q   <= in_item_i.start_x;
      sy1_q   <= in_item_i.start_y;
      dx1_q   <= (CoordW+1)'(in_item_i.toward_x) - (CoordW+1)'(in_item_i.start_x);
      dy1_q   <= (CoordW+1)'(in_item_i.toward_y) - (CoordW+1)'(in_item_i.start_y);
      ccw1_q  <= dir_q ^ in_item_i.req_type;
      lead1_q <= lead_q;
    end
  end

  // stage 2: magnitudes and signs
  logic             v2_q;
  side_t            side2_q;
  logic [MagW-1:0]  ax2_q, ay2_q;
  logic [LeadW-1:0] lead2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side2_q.sx   <= sx1_q;
      side2_q.sy   <= sy1_q;
      side2_q.negx <= dx1_q[CoordW];
      side2_q.negy <= dy1_q[CoordW];
      side2_q.ccw  <= ccw1_q;
      side2_q.deg  <= (dx1_q == '0) && (dy1_q == '0);
      ax2_q        <= dx1_q[CoordW] ? MagW'(-dx1_q) : MagW'(dx1_q);
      ay2_q        <= dy1_q[CoordW] ? MagW'(-dy1_q) : MagW'(dy1_q);
      lead2_q      <= lead1_q;
    end
  end

  // stage 3: squares of the components, lead times each component
  logic                  v3_q;
  side_t                 side3_q;
  logic [2*MagW-1:0]     sqx3_q, sqy3_q;
  logic [LeadW+MagW-1:0] lx3_q, ly3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side3_q <= side2_q;
      sqx3_q  <= (2*MagW)'(ax2_q) * (2*MagW)'(ax2_q);
      sqy3_q  <= (2*MagW)'(ay2_q) * (2*MagW)'(ay2_q);
      lx3_q   <= (LeadW+MagW)'(lead2_q) * (LeadW+MagW)'(ax2_q);
      ly3_q   <= (LeadW+MagW)'(lead2_q) * (LeadW+MagW)'(ay2_q);
    end
  end

  // stage 4: squared length; partial products of (2*L*m)^2
  logic [ProdW-1:0] px3, py3;
  logic             v4_q;
  side_t            side4_q;
  logic [DenW-1:0]  den4_q;
  logic [2*HiW-1:0] hhx4_q, hhy4_q;
  logic [HiW+LoW-1:0] hlx4_q, hly4_q;
  logic [2*LoW-1:0] llx4_q, lly4_q;

  assign px3 = {lx3_q, 1'b0};
  assign py3 = {ly3_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side4_q <= side3_q;
      // keep the divider away from zero; the start point is chosen later
      den4_q  <= side3_q.deg ? DenW'(1) : DenW'(sqx3_q) + DenW'(sqy3_q);
      hhx4_q  <= (2*HiW)'(px3[ProdW-1:LoW]) * (2*HiW)'(px3[ProdW-1:LoW]);
      hly4_q  <= (HiW+LoW)'(py3[ProdW-1:LoW]) * (HiW+LoW)'(py3[LoW-1:0]);
      hhy4_q  <= (2*HiW)'(py3[ProdW-1:LoW]) * (2*HiW)'(py3[ProdW-1:LoW]);
      hlx4_q  <= (HiW+LoW)'(px3[ProdW-1:LoW]) * (HiW+LoW)'(px3[LoW-1:0]);
      llx4_q  <= (2*LoW)'(px3[LoW-1:0]) * (2*LoW)'(px3[LoW-1:0]);
      lly4_q  <= (2*LoW)'(py3[LoW-1:0]) * (2*LoW)'(py3[LoW-1:0]);
    end
  end

  // stage 5: sum the partial products
  logic            v5_q;
  side_t           side5_q;
  logic [DenW-1:0] den5_q;
  logic [NumW-1:0] numx5_q, numy5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side5_q <= side4_q;
      den5_q  <= den4_q;
      numx5_q <= (NumW'(hhx4_q) << (2*LoW)) + (NumW'(hlx4_q) << (LoW+1)) + NumW'(llx4_q);
      numy5_q <= (NumW'(hhy4_q) << (2*LoW)) + (NumW'(hly4_q) << (LoW+1)) + NumW'(lly4_q);
    end
  end

  // divide and root, one unit per component; sideband rides alongside
  logic [RootW-1:0] rootx, rooty;

  pop_root_ratio u_ratio_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (numx5_q),
    .den_i  (den5_q),
    .root_o (rootx)
  );

  pop_root_ratio u_ratio_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (numy5_q),
    .den_i  (den5_q),
    .root_o (rooty)
  );

  logic  vp_q   [Lat];
  side_t side_q [Lat];

  for (genvar i = 0; i < Lat; i++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vp_q[i] <= 1'b0;
      end else if (en) begin
        vp_q[i] <= (i == 0) ? v5_q : vp_q[(i == 0) ? 0 : i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[i] <= (i == 0) ? side5_q : side_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  // round: the largest odd k not above the root gives q = (k+1)/2
  logic [RootW:0]   incx, incy;
  logic             vq_q;
  side_t            sideq_q;
  logic [RootW-1:0] qx_q, qy_q;

  assign incx = {1'b0, rootx} + (RootW+1)'(1);
  assign incy = {1'b0, rooty} + (RootW+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq_q <= 1'b0;
    end else if (en) begin
      vq_q <= vp_q[Lat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sideq_q <= side_q[Lat-1];
      qx_q    <= incx[RootW:1];
      qy_q    <= incy[RootW:1];
    end
  end

  // apply the rotation sense and saturate
  function automatic pop_pkg::coord_t sat(logic signed [CoordW+1:0] v);
    logic signed [CoordW+1:0] hi;
    logic signed [CoordW+1:0] lo;
    hi = (CoordW+2)'({1'b0, {(CoordW-1){1'b1}}});
    lo = -hi - (CoordW+2)'(1);
    if (v > hi) begin
      return pop_pkg::coord_t'(hi[CoordW-1:0]);
    end else if (v < lo) begin
      return pop_pkg::coord_t'(lo[CoordW-1:0]);
    end
    return pop_pkg::coord_t'(v[CoordW-1:0]);
  endfunction

  logic signed [CoordW+1:0] sxe, sye, qxe, qye, sumx, sumy;
  logic                     subx, suby;
  pop_pkg::out_item_t       tail;

  always_comb begin
    sxe  = (CoordW+2)'(sideq_q.sx);
    sye  = (CoordW+2)'(sideq_q.sy);
    qxe  = signed'((CoordW+2)'(qx_q));
    qye  = signed'((CoordW+2)'(qy_q));
    subx = sideq_q.ccw ^ sideq_q.negy;
    suby = !sideq_q.ccw ^ sideq_q.negx;
    sumx = subx ? sxe - qye : sxe + qye;
    sumy = suby ? sye - qxe : sye + qxe;
    tail.degenerate = sideq_q.deg;
    tail.offset_x   = sideq_q.deg ? sideq_q.sx : sat(sumx);
    tail.offset_y   = sideq_q.deg ? sideq_q.sy : sat(sumy);
  end

  // ---------------------------------------------------------------- output
  logic               out_v_q;
  pop_pkg::out_item_t out_q;
  pop_pkg::out_item_t skid_q;
  logic               take;

  assign take = en && vq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      priority if (skid_v_q) begin
        if (!out_stall_i) begin
          skid_v_q <= 1'b0;
        end
      end else if (take) begin
        if (!out_v_q || !out_stall_i) begin
          out_v_q <= 1'b1;
        end else begin
          skid_v_q <= 1'b1;
        end
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (skid_v_q) begin
      if (!out_stall_i) begin
        out_q <= skid_q;
      end
    end else if (take) begin
      if (!out_v_q || !out_stall_i) begin
        out_q <= tail;
      end else begin
        skid_q <= tail;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  // ---------------------------------------------------------------- checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds an item while the output is empty");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && out_stall_i))
    else $error("skid register filled without a stalled output");

  a_stall_output_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled while the output is empty");

endmodule
`default_nettype wire

FILE: bench/tb_perpendicular_offset_point.sv
`default_nettype none
module tb_perpendicular_offset_point;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AddrW = pop_pkg::AddrW;
  localparam int unsigned DataW = pop_pkg::DataW;
  localparam int unsigned LeadW = pop_pkg::LeadW;

  // Register byte addresses on the APB port.
  localparam logic [AddrW-1:0] ADDR_DIR_LEFT = 3'h0;
  localparam logic [AddrW-1:0] ADDR_LEAD     = 3'h4;
  localparam logic [LeadW-1:0] LEAD_MAX      = 31'h7FFF_FFFF;
  localparam int unsigned      CYCLE_LIMIT   = 600000;
  localparam int unsigned      DRAIN_CYCLES  = pop_pkg::Lat + 50;
  localparam int unsigned      LONG_HOLD     = 400;

  typedef logic [139:0] wide_t;

  // One directed row: the setting it runs under, the item, and optionally
  // the expected result when it is obvious.
  typedef struct {
    logic               dir_left;
    logic [LeadW-1:0]   lead;
    pop_pkg::in_item_t  item;
    bit                 known;
    pop_pkg::out_item_t result;
  } row_t;

  logic               clk_i, rst_ni;
  logic               in_valid_i, in_stall_o;
  pop_pkg::in_item_t  in_item_i;
  logic               out_valid_o, out_stall_i;
  pop_pkg::out_item_t out_item_o;
  logic               psel, penable, pwrite, pready;
  logic [AddrW-1:0]   paddr;
  logic [DataW-1:0]   pwdata, prdata;

  perpendicular_offset_point DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Shadow copy of the two registers.
  logic             cur_dir_left;
  logic [LeadW-1:0] cur_lead;

  pop_pkg::out_item_t pending_points[$];
  row_t               rows[$];
  int unsigned        mismatches;
  int unsigned        cycles;
  bit                 busy_sender;   // no idling on the input side when set
  bit                 busy_receiver; // no random stall on the output side when set
  bit                 start_hold, hold_long;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Rounded magnitude of lead*m/sqrt(d2), halves away from zero, capped at lead.
  function automatic logic [31:0] scaled_component(logic [LeadW-1:0] lead, logic [32:0] m,
                                                    wide_t d2);
    wide_t       t, rhs, k, lhs;
    logic [32:0] q, cand;
    t = wide_t'(lead) * wide_t'(m);
    t = t + t;
    rhs = t * t;
    q = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = q | (33'd1 << b);
      k = wide_t'(2 * cand - 1);
      lhs = k * k * d2;
      if (cand <= {2'b0, lead} && lhs <= rhs) q = cand;
    end
    return q[31:0];
  endfunction

  function automatic pop_pkg::coord_t clamp_coord(logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return pop_pkg::coord_t'(32'h7FFF_FFFF);
    if (v < -64'sh8000_0000) return pop_pkg::coord_t'(32'h8000_0000);
    return pop_pkg::coord_t'(v[31:0]);
  endfunction

  function automatic pop_pkg::out_item_t offset_point(pop_pkg::in_item_t it, logic dir_left,
                                                      logic [LeadW-1:0] lead);
    logic signed [63:0] sx, sy, dx, dy, px, py, ox, oy;
    logic [32:0]        ax, ay;
    wide_t              d2;
    pop_pkg::out_item_t r;
    sx = 64'(it.start_x);
    sy = 64'(it.start_y);
    dx = 64'(it.toward_x) - sx;
    dy = 64'(it.toward_y) - sy;
    if (dx == 0 && dy == 0) begin
      r.offset_x = it.start_x;
      r.offset_y = it.start_y;
      r.degenerate = 1'b1;
      return r;
    end
    ax = dx < 0 ? 33'(-dx) : 33'(dx);
    ay = dy < 0 ? 33'(-dy) : 33'(dy);
    d2 = wide_t'(ax) * wide_t'(ax) + wide_t'(ay) * wide_t'(ay);
    px = 64'(scaled_component(lead, ax, d2));
    py = 64'(scaled_component(lead, ay, d2));
    if (dx < 0) px = -px;
    if (dy < 0) py = -py;
    // Counter-clockwise when the tool side and the lead variant disagree.
    if (dir_left != it.req_type) begin
      ox = sx - py;
      oy = sy + px;
    end else begin
      ox = sx + py;
      oy = sy - px;
    end
    r.offset_x = clamp_coord(ox);
    r.offset_y = clamp_coord(oy);
    r.degenerate = 1'b0;
    return r;
  endfunction

  function automatic pop_pkg::in_item_t seg(logic req, logic [31:0] sx, logic [31:0] sy,
                                            logic [31:0] tx, logic [31:0] ty);
    pop_pkg::in_item_t it;
    it.req_type = req;
    it.start_x = sx;
    it.start_y = sy;
    it.toward_x = tx;
    it.toward_y = ty;
    return it;
  endfunction

  function automatic pop_pkg::out_item_t pt(logic [31:0] x, logic [31:0] y, logic degen);
    pop_pkg::out_item_t r;
    r.offset_x = x;
    r.offset_y = y;
    r.degenerate = degen;
    return r;
  endfunction

  function automatic row_t mk_row(logic dir_left, logic [LeadW-1:0] lead,
                                  pop_pkg::in_item_t it, bit known,
                                  pop_pkg::out_item_t r);
    row_t w;
    w.dir_left = dir_left;
    w.lead = lead;
    w.item = it;
    w.known = known;
    w.result = r;
    return w;
  endfunction

  // Random gap: mostly short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Random segment: short and long segments at random places, plus extremes,
  // axis-aligned, and zero-length ones.
  function automatic pop_pkg::in_item_t random_segment();
    logic [31:0] sx, sy, tx, ty;
    int unsigned kind;
    kind = $urandom_range(9);
    sx = $urandom();
    sy = $urandom();
    case (kind)
      0, 1: begin
        tx = $urandom();
        ty = $urandom();
      end
      2, 3, 4: begin
        tx = sx + 32'($signed($urandom_range(200000)) - 100000);
        ty = sy + 32'($signed($urandom_range(200000)) - 100000);
      end
      5: begin
        tx = sx + 32'($signed($urandom_range(8)) - 4);
        ty = sy + 32'($signed($urandom_range(8)) - 4);
      end
      6: begin
        tx = $urandom_range(1) ? sx : $urandom();
        ty = (tx == sx) ? $urandom() : sy;
      end
      7: begin
        tx = sx;
        ty = sy;
      end
      default: begin
        sx = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        sy = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        tx = $urandom_range(1) ? ~sx : $urandom();
        ty = $urandom_range(1) ? ~sy : $urandom();
      end
    endcase
    return seg(1'($urandom_range(1)), sx, sy, tx, ty);
  endfunction

  task automatic write_reg(logic [AddrW-1:0] addr, logic [DataW-1:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Drop the input, wait for the pipeline to empty, then load a new setting.
  task automatic apply_setting(logic dir_left, logic [LeadW-1:0] lead);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_points.size() == 0);
    write_reg(ADDR_DIR_LEFT, {31'b0, dir_left});
    write_reg(ADDR_LEAD, {1'b0, lead});
    cur_dir_left = dir_left;
    cur_lead = lead;
  endtask

  // Offer one item, hold it until accepted, then idle for a random gap unless busy_sender is set.
  task automatic send_segment(pop_pkg::in_item_t it, bit known, pop_pkg::out_item_t r);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    pending_points.insert(pending_points.size(),
                          known ? r : offset_point(it, cur_dir_left, cur_lead));
    gap = busy_sender ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Receiver stall: random, forced low while busy_receiver is set, or forced high through a long hold.
  always @(negedge clk_i) begin
    if (hold_long) begin
      out_stall_i <= 1'b1;
    end else if (busy_receiver) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 25);
    end
  end

  // Long receiver hold, counted here so the sender keeps offering items.
  initial begin
    hold_long = 1'b0;
    wait (start_hold);
    @(posedge clk_i);
    hold_long = 1'b1;
    repeat (LONG_HOLD) @(posedge clk_i);
    hold_long = 1'b0;
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    pop_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item_o);
      end else begin
        want = pending_points.pop_front();
        if (out_item_o.offset_x !== want.offset_x || out_item_o.offset_y !== want.offset_y ||
            out_item_o.degenerate !== want.degenerate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%h y=%h deg=%b, got x=%h y=%h deg=%b",
                     want.offset_x, want.offset_y, want.degenerate,
                     out_item_o.offset_x, out_item_o.offset_y, out_item_o.degenerate);
        end
      end
    end
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic             dir_sel;
    logic [LeadW-1:0] lead_sel;
    mismatches = 0;
    cycles = 0;
    busy_sender = 1'b0;
    busy_receiver = 1'b0;
    start_hold = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_stall_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cur_dir_left = 1'b1;
    cur_lead = '0;

    // Directed table: reset defaults first, then extremes and each rotation.
    rows = {rows, mk_row(1'b1, 31'd0, seg(1'b0, 32'd1, 32'd2, 32'd3, 32'd4), 1'b1,
                         pt(32'd1, 32'd2, 1'b0))};
    rows = {rows, mk_row(1'b1, 31'd0, seg(1'b1, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h8000_0000), 1'b1,
                         pt(32'h8000_0000, 32'h7FFF_FFFF, 1'b0))};
    rows = {rows, mk_row(1'b1, 31'd0, seg(1'b0, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'h8000_0000), 1'b1,
                         pt(32'h7FFF_FFFF, 32'h8000_0000, 1'b1))};
    rows = {rows, mk_row(1'b1, 31'h10000, seg(1'b0, 32'd0, 32'd0, 32'h10000, 32'd0),
                         1'b0, '0)};
    rows = {rows, mk_row(1'b1, 31'h10000, seg(1'b1, 32'd0, 32'd0, 32'h10000, 32'd0),
                         1'b0, '0)};
    rows = {rows, mk_row(1'b1, 31'h10000, seg(1'b0, 32'd0, 32'd0, 32'd0, 32'hFFFF_0000),
                         1'b0, '0)};
    rows = {rows, mk_row(1'b0, 31'h10000, seg(1'b0, 32'd0, 32'd0, 32'h10000, 32'd0),
                         1'b0, '0)};
    rows = {rows, mk_row(1'b0, 31'h10000, seg(1'b1, 32'd0, 32'd0, 32'h10000, 32'd0),
                         1'b0, '0)};
    rows = {rows, mk_row(1'b0, 31'h50000, seg(1'b0, 32'h1234, 32'h5678, 32'h31234,
                         32'h45678), 1'b0, '0)};
    rows = {rows, mk_row(1'b0, 31'd3, seg(1'b1, 32'd0, 32'd0, 32'd1, 32'd1), 1'b0, '0)};
    rows = {rows, mk_row(1'b0, LEAD_MAX, seg(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h8000_0000), 1'b0, '0)};
    rows = {rows, mk_row(1'b0, LEAD_MAX, seg(1'b1, 32'h8000_0000, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b0, '0)};
    rows = {rows, mk_row(1'b1, LEAD_MAX, seg(1'b0, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h8000_0001, 32'h8000_0000), 1'b0, '0)};
    rows = {rows, mk_row(1'b1, LEAD_MAX, seg(1'b1, 32'h8000_0000, 32'h0, 32'h8000_0000,
                         32'h0), 1'b1, pt(32'h8000_0000, 32'd0, 1'b1))};
    rows = {rows, mk_row(1'b1, LEAD_MAX, seg(1'b0, 32'd0, 32'd0, 32'd1, 32'd0),
                         1'b0, '0)};

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].dir_left !== cur_dir_left || rows[i].lead !== cur_lead)
        apply_setting(rows[i].dir_left, rows[i].lead);
      send_segment(rows[i].item, rows[i].known, rows[i].result);
    end

    // Random phases across several settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      dir_sel = 1'($urandom_range(1));
      case (ph)
        0: lead_sel = LEAD_MAX;
        1: lead_sel = '0;
        2: lead_sel = 31'($urandom_range(32'h40000));
        3: lead_sel = 31'($urandom());
        4: lead_sel = 31'd1;
        default: lead_sel = 31'($urandom_range(32'h100000));
      endcase
      apply_setting(dir_sel, lead_sel);
      busy_sender = (ph == 2 || ph == 4);
      busy_receiver = (ph == 4);
      for (int n = 0; n < 100; n++) begin
        // Fill the pipeline behind a long receiver hold.
        if (ph == 2 && n == 5) start_hold = 1'b1;
        send_segment(random_segment(), 1'b0, '0);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_points.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
